[src/pidfd_pkg.sv]
package pidfd_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ACC_WIDTH = 48;
  localparam int MUL_W     = 33;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int NUM_W     = 64;
  localparam int DEN_W     = 33;

  typedef logic signed [63:0] s64_t;
  typedef logic signed [31:0] s32_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CA_MUL,
    ST_CA_DIV,
    ST_DA,
    ST_DB,
    ST_P,
    ST_A,
    ST_B,
    ST_K,
    ST_H,
    ST_I,
    ST_U,
    ST_O
  } state_e;

  typedef enum logic [2:0] {
    REG_PROP_GAIN,
    REG_INT_GAIN,
    REG_DERIV_GAIN,
    REG_DERIV_FILT,
    REG_FILTER_TIME,
    REG_SAMPLE_PERIOD,
    REG_OUT_LOW,
    REG_OUT_HIGH
  } reg_idx_e;

  function automatic s32_t sat32(input s64_t x);
    s32_t r;
    if (x > 64'sd2147483647) r = 32'sh7fffffff;
    else if (x < -64'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

  function automatic s64_t sadd64(input s64_t a, input s64_t b);
    logic signed [64:0] s;
    s64_t r;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) r = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else r = s[63:0];
    return r;
  endfunction

  // saturate to accumulator width, result sign-extended to 64 bits
  function automatic s64_t sat_acc(input s64_t x);
    s64_t hi;
    s64_t lo;
    s64_t r;
    hi = s64_t'((65'sd1 <<< (ACC_WIDTH - 1)) - 65'sd1);
    lo = -hi - 64'sd1;
    if (x > hi) r = hi;
    else if (x < lo) r = lo;
    else r = x;
    return r;
  endfunction

  function automatic s32_t signed_q32(input logic [NUM_W-1:0] mag, input logic neg);
    s32_t r;
    if (neg) begin
      if (mag > 64'h80000000) r = 32'sh80000000;
      else r = s32_t'(-$signed({1'b0, mag[31:0]}));
    end else begin
      if (mag > 64'h7fffffff) r = 32'sh7fffffff;
      else r = mag[31:0];
    end
    return r;
  endfunction

endpackage

[src/pidfd_mul.sv]
module pidfd_mul
  import pidfd_pkg::*;
(
  input  logic                     clk_i,
  input  logic signed [MUL_W-1:0]  a_i,
  input  logic signed [MUL_W-1:0]  b_i,
  output logic signed [PROD_W-1:0] prod_o
);

  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule

[src/pidfd_div.sv]
module pidfd_div
  import pidfd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quot_q, quot_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quot_q[NUM_W-1]};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d  = DEN_W'(trial - {1'b0, den_q});
        quot_d = {quot_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d  = trial[DEN_W-1:0];
        quot_d = {quot_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

[src/pid_filtered_derivative_antiwindup_top.sv]
// PID controller with Tustin-filtered derivative and conditional-integration
// anti-windup, signed Q16.16 throughout. A control step (tuser = 0) walks eight
// states on one shared 33x33 multiplier: the result is registered in the last
// state, and the next transaction is taken once the block is back in idle; the
// last state holds while the previous result still waits on m_axis_tready.
// The first step after reset or after any gain, filter time or period write
// first recomputes the derivative coefficients on a radix-2 divider (two
// 64-bit quotients, after a multiply state and a set-up state), which is skipped
// when the denominator is zero. A clear transaction (tuser = 1) zeroes the
// controller state and gives no result. The block takes one transaction at a
// time; write configuration only while idle.
module pid_filtered_derivative_antiwindup_top
  import pidfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] error
  input  logic        s_axis_tuser,   // [0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] drive
  output logic [1:0]  m_axis_tuser    // [0] held_high, [1] held_low
);

  state_e state_q, state_d;

  s32_t        kp_q, ki_q, kd_q, kf_q, lo_q, hi_q;
  logic [30:0] tf_q, tp_q;
  logic        stale_q;

  logic [ACC_WIDTH-1:0] integ_q;
  s32_t last_err_q, last_d_q, ca_q, cb_q, e_q, d_q, k_q;
  s64_t p_q, ta_q, pre_q;
  logic hh_q, hl_q;

  logic        out_valid_q;
  s32_t        out_drive_q;
  logic [1:0]  out_flags_q;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  s64_t                     prod_sh;
  logic                     div_start, div_done;
  logic [NUM_W-1:0]         div_num, div_quot;
  logic [DEN_W-1:0]         den;
  logic signed [DEN_W-1:0]  nb;
  logic [DEN_W-1:0]         nb_mag;
  logic                     in_acc;
  s64_t                     integ_ext, fin;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign den       = {1'b0, tf_q, 1'b0} + {2'b00, tp_q};
  assign nb        = $signed({1'b0, tf_q, 1'b0}) - $signed({2'b00, tp_q});
  assign nb_mag    = nb[DEN_W-1] ? DEN_W'(-nb) : nb;
  assign prod_sh   = s64_t'(prod >>> FRAC_BITS);
  assign integ_ext = s64_t'($signed(integ_q));
  assign fin       = sadd64(sadd64(p_q, integ_ext), s64_t'(d_q));

  pidfd_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  pidfd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // operand selection and next state
  always_comb begin
    state_d   = state_q;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && !s_axis_tuser) state_d = stale_q ? ST_CA_MUL : ST_P;
      end
      ST_CA_MUL: begin
        mul_a   = kf_q[31] ? MUL_W'(-$signed({kf_q[31], kf_q})) : MUL_W'(kf_q);
        mul_b   = kd_q[31] ? MUL_W'(-$signed({kd_q[31], kd_q})) : MUL_W'(kd_q);
        state_d = ST_CA_DIV;
      end
      ST_CA_DIV: begin
        if (den == '0) begin
          state_d = ST_P;
        end else begin
          div_start = 1'b1;
          div_num   = {prod[NUM_W-2:0], 1'b0};
          state_d   = ST_DA;
        end
      end
      ST_DA: begin
        if (div_done) begin
          div_start = 1'b1;
          div_num   = NUM_W'(nb_mag) << FRAC_BITS;
          state_d   = ST_DB;
        end
      end
      ST_DB: begin
        if (div_done) state_d = ST_P;
      end
      ST_P: begin
        mul_a   = MUL_W'(kp_q);
        mul_b   = MUL_W'(e_q);
        state_d = ST_A;
      end
      ST_A: begin
        mul_a   = MUL_W'(ca_q);
        mul_b   = MUL_W'(e_q) - MUL_W'(last_err_q);
        state_d = ST_B;
      end
      ST_B: begin
        mul_a   = MUL_W'(cb_q);
        mul_b   = MUL_W'(last_d_q);
        state_d = ST_K;
      end
      ST_K: begin
        mul_a   = MUL_W'(ki_q);
        mul_b   = $signed({2'b00, tp_q});
        state_d = ST_H;
      end
      ST_H: state_d = ST_I;
      ST_I: begin
        mul_a   = MUL_W'(k_q);
        mul_b   = MUL_W'(e_q) + MUL_W'(last_err_q);
        state_d = ST_U;
      end
      ST_U: state_d = ST_O;
      ST_O: begin
        if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kp_q        <= '0;
      ki_q        <= '0;
      kd_q        <= '0;
      kf_q        <= '0;
      tf_q        <= '0;
      tp_q        <= '0;
      lo_q        <= 32'sh80000000;
      hi_q        <= 32'sh7fffffff;
      stale_q     <= 1'b1;
      integ_q     <= '0;
      last_err_q  <= '0;
      last_d_q    <= '0;
      ca_q        <= '0;
      cb_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_PROP_GAIN:     begin kp_q <= cfg_wdata_i; stale_q <= 1'b1; end
          REG_INT_GAIN:      begin ki_q <= cfg_wdata_i; stale_q <= 1'b1; end
          REG_DERIV_GAIN:    begin kd_q <= cfg_wdata_i; stale_q <= 1'b1; end
          REG_DERIV_FILT:    begin kf_q <= cfg_wdata_i; stale_q <= 1'b1; end
          REG_FILTER_TIME:   begin tf_q <= cfg_wdata_i[30:0]; stale_q <= 1'b1; end
          REG_SAMPLE_PERIOD: begin tp_q <= cfg_wdata_i[30:0]; stale_q <= 1'b1; end
          REG_OUT_LOW:       lo_q <= cfg_wdata_i;
          REG_OUT_HIGH:      hi_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      // a new result may replace the one leaving in the same cycle
      if (state_q == ST_O && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc && s_axis_tuser) begin
            integ_q    <= '0;
            last_err_q <= '0;
            last_d_q   <= '0;
          end
        end
        ST_CA_DIV: begin
          if (den == '0) begin
            ca_q    <= '0;
            cb_q    <= '0;
            stale_q <= 1'b0;
          end
        end
        ST_DA: if (div_done) ca_q <= signed_q32(div_quot, kf_q[31] != kd_q[31]);
        ST_DB: begin
          if (div_done) begin
            cb_q    <= signed_q32(div_quot, nb[DEN_W-1]);
            stale_q <= 1'b0;
          end
        end
        ST_U: begin
          if (!hh_q && !hl_q)
            integ_q <= ACC_WIDTH'(sat_acc(sadd64(integ_ext, prod_sh)));
        end
        ST_O: begin
          if (!out_valid_q || m_axis_tready) begin
            last_err_q  <= e_q;
            last_d_q    <= d_q;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_acc) e_q <= s_axis_tdata;
    if (state_q == ST_A) p_q <= prod_sh;
    if (state_q == ST_B) ta_q <= prod_sh;
    if (state_q == ST_K) d_q <= sat32(sadd64(ta_q, prod_sh));
    if (state_q == ST_H) begin
      k_q   <= sat32(s64_t'(prod >>> (FRAC_BITS + 1)));
      pre_q <= sadd64(sadd64(p_q, integ_ext), s64_t'(d_q));
    end
    if (state_q == ST_I) begin
      hh_q <= (pre_q >= s64_t'(hi_q)) && (e_q > 0);
      hl_q <= (pre_q <= s64_t'(lo_q)) && (e_q < 0);
    end
    if (state_q == ST_O && (!out_valid_q || m_axis_tready)) begin
      if (fin < s64_t'(lo_q)) out_drive_q <= lo_q;
      else if (fin > s64_t'(hi_q)) out_drive_q <= hi_q;
      else out_drive_q <= fin[31:0];
      out_flags_q <= {hl_q, hh_q};
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_drive_q;
  assign m_axis_tuser  = out_flags_q;

endmodule

[sim/pid_filtered_derivative_antiwindup_top_test.sv]
`timescale 1ns / 100ps

module pid_filtered_derivative_antiwindup_top_test
  import pidfd_pkg::*;
;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 200;
  localparam int TOTAL_ITEMS    = 1850;
  localparam bit KIND_STEP      = 1'b0;
  localparam bit KIND_CLEAR     = 1'b1;

  typedef struct packed {
    logic [31:0] drive;
    logic        held_high;
    logic        held_low;
  } drive_t;

  class pid_scoreboard;
    longint kp, ki, kd, kf, tf, tp, lim_lo, lim_hi;
    longint integ, prev_err, prev_deriv, coef_a, coef_b;
    bit     coef_stale;
    drive_t drive_q[$];
    int     errors;

    function new();
      kp = 0; ki = 0; kd = 0; kf = 0; tf = 0; tp = 0;
      lim_lo = -64'sd2147483648; lim_hi = 64'sd2147483647;
      integ = 0; prev_err = 0; prev_deriv = 0; coef_a = 0; coef_b = 0;
      coef_stale = 1'b1;
      errors = 0;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    function int pending();
      return drive_q.size();
    endfunction

    function void write_reg(reg_idx_e idx, logic [31:0] v);
      case (idx)
        REG_PROP_GAIN:     begin kp = longint'($signed(v)); coef_stale = 1'b1; end
        REG_INT_GAIN:      begin ki = longint'($signed(v)); coef_stale = 1'b1; end
        REG_DERIV_GAIN:    begin kd = longint'($signed(v)); coef_stale = 1'b1; end
        REG_DERIV_FILT:    begin kf = longint'($signed(v)); coef_stale = 1'b1; end
        REG_FILTER_TIME:   begin tf = longint'({33'd0, v[30:0]}); coef_stale = 1'b1; end
        REG_SAMPLE_PERIOD: begin tp = longint'({33'd0, v[30:0]}); coef_stale = 1'b1; end
        REG_OUT_LOW:       lim_lo = longint'($signed(v));
        REG_OUT_HIGH:      lim_hi = longint'($signed(v));
        default: ;
      endcase
    endfunction

    function longint sat32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function longint sat_add(longint a, longint b);
      longint s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63])
        return a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      return s;
    endfunction

    function longint unsigned magnitude(longint x);
      return x < 0 ? longint'(-x) : x;
    endfunction

    function longint quot_q32(longint unsigned q, bit neg);
      if (neg) return (q > 64'h80000000) ? -64'sd2147483648 : -longint'(q);
      return (q > 64'h7fffffff) ? 64'sd2147483647 : longint'(q);
    endfunction

    function void update_coefs();
      longint unsigned den, num;
      longint n;
      den = 2 * tf + tp;
      if (den == 0) begin
        coef_a = 0;
        coef_b = 0;
      end else begin
        num = 2 * magnitude(kf) * magnitude(kd);
        coef_a = quot_q32(num / den, (kf < 0) != (kd < 0));
        n = 2 * tf - tp;
        num = magnitude(n) << FRAC_BITS;
        coef_b = quot_q32(num / den, n < 0);
      end
    endfunction

    function void note_input(bit kind, logic [31:0] err_bits);
      longint e, p, d, pre, fin, k, inc, acc_hi;
      drive_t res;
      if (kind == KIND_CLEAR) begin
        integ = 0; prev_err = 0; prev_deriv = 0;
        return;
      end
      e = longint'($signed(err_bits));
      if (coef_stale) begin
        update_coefs();
        coef_stale = 1'b0;
      end
      p = (kp * e) >>> FRAC_BITS;
      d = sat32(sat_add((coef_a * (e - prev_err)) >>> FRAC_BITS,
                        (coef_b * prev_deriv) >>> FRAC_BITS));
      pre = sat_add(sat_add(p, integ), d);
      res.held_high = (pre >= lim_hi) && (e > 0);
      res.held_low  = (pre <= lim_lo) && (e < 0);
      if (!res.held_high && !res.held_low) begin
        k = sat32((ki * tp) >>> (FRAC_BITS + 1));
        inc = (k * (e + prev_err)) >>> FRAC_BITS;
        acc_hi = (64'sd1 <<< (ACC_WIDTH - 1)) - 1;
        integ = sat_add(integ, inc);
        if (integ > acc_hi) integ = acc_hi;
        else if (integ < -acc_hi - 1) integ = -acc_hi - 1;
      end
      fin = sat_add(sat_add(p, integ), d);
      if (fin < lim_lo) fin = lim_lo;
      else if (fin > lim_hi) fin = lim_hi;
      prev_err = e;
      prev_deriv = d;
      res.drive = fin[31:0];
      drive_q.push_back(res);
    endfunction

    task check_result(logic [31:0] drive, logic [1:0] flags);
      drive_t want;
      if (drive_q.size() == 0) begin
        report("unexpected drive", drive, 32'd0);
        return;
      end
      want = drive_q.pop_front();
      if (drive !== want.drive) report("drive", drive, want.drive);
      if (flags[0] !== want.held_high) report("held_high", flags[0], want.held_high);
      if (flags[1] !== want.held_low) report("held_low", flags[1], want.held_low);
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  pid_scoreboard sb;
  bit quiet;
  int stall_left;
  int idle_cycles;
  int sent;

  pid_filtered_derivative_antiwindup_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver back-pressure
  always @(negedge clk_i) begin
    if (quiet) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < 30) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_item(bit kind, logic [31:0] err);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= err;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(kind, err);
    sent++;
  endtask

  // drop valid and hold off until every drive value is back
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  function logic [31:0] rand_gain();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      2: return 32'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
      3: return ($urandom_range(0, 1)) ? 32'h7fffffff : 32'h80000000;
      default: return 32'd0;
    endcase
  endfunction

  function logic [31:0] rand_time();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'h7fffffff;
      2: return $urandom();
      default: return $urandom_range(1, 2 << 16);
    endcase
  endfunction

  function logic [31:0] rand_error();
    if ($urandom_range(0, 9) < 3) return $urandom();
    return 32'($signed($urandom_range(0, 16 << 16)) - (8 << 16));
  endfunction

  task automatic random_config(bit all_regs);
    logic [31:0] a, b;
    reg_idx_e idx;
    for (int i = 0; i < 6; i++) begin
      idx = reg_idx_e'(i);
      if (all_regs || $urandom_range(0, 2) == 0)
        write_reg(idx, (i >= 4) ? rand_time() : rand_gain());
    end
    if (all_regs || $urandom_range(0, 1) == 0) begin
      a = 32'($signed($urandom_range(0, 64 << 16)) - (32 << 16));
      b = 32'($signed($urandom_range(0, 64 << 16)) - (32 << 16));
      case ($urandom_range(0, 5))
        0: begin a = 32'h80000000; b = 32'h7fffffff; end
        1: ;  // may come out inverted
        default: if ($signed(a) > $signed(b)) begin a ^= b; b ^= a; a ^= b; end
      endcase
      write_reg(REG_OUT_LOW, a);
      write_reg(REG_OUT_HIGH, b);
    end
  endtask

  initial begin
    int phase_len;
    sb = new();
    quiet = 1'b0;
    stall_left = 0;
    idle_cycles = 0;
    sent = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset gains: zero denominator, zero coefficients
    send_item(KIND_STEP, 32'h7fffffff);
    send_item(KIND_STEP, 32'h80000000);
    wait_idle();

    write_reg(REG_PROP_GAIN, 32'h0001_0000);
    write_reg(REG_INT_GAIN, 32'h0002_0000);
    write_reg(REG_DERIV_GAIN, 32'h0000_8000);
    write_reg(REG_DERIV_FILT, 32'h0004_0000);
    write_reg(REG_FILTER_TIME, 32'h0000_1000);
    write_reg(REG_SAMPLE_PERIOD, 32'h0000_0100);
    write_reg(REG_OUT_LOW, 32'hfff0_0000);
    write_reg(REG_OUT_HIGH, 32'h0010_0000);
    send_item(KIND_STEP, 32'h0000_0000);
    send_item(KIND_STEP, 32'h0001_0000);
    send_item(KIND_STEP, 32'h7fffffff);
    send_item(KIND_STEP, 32'h7fffffff);
    send_item(KIND_STEP, 32'h80000000);
    send_item(KIND_STEP, 32'h80000000);
    send_item(KIND_STEP, 32'hffffffff);
    send_item(KIND_CLEAR, 32'hffffffff);
    send_item(KIND_STEP, 32'h0000_0001);
    wait_idle();

    // extreme gains and times, inverted limits
    write_reg(REG_PROP_GAIN, 32'h80000000);
    write_reg(REG_INT_GAIN, 32'h7fffffff);
    write_reg(REG_DERIV_GAIN, 32'h80000000);
    write_reg(REG_DERIV_FILT, 32'h7fffffff);
    write_reg(REG_FILTER_TIME, 32'h7fffffff);
    write_reg(REG_SAMPLE_PERIOD, 32'h7fffffff);
    write_reg(REG_OUT_LOW, 32'h0001_0000);
    write_reg(REG_OUT_HIGH, 32'hffff_0000);
    send_item(KIND_STEP, 32'h7fffffff);
    send_item(KIND_STEP, 32'h80000000);
    send_item(KIND_STEP, 32'h0000_0000);
    wait_idle();
    write_reg(REG_FILTER_TIME, 32'h0000_0000);
    write_reg(REG_SAMPLE_PERIOD, 32'h0000_0001);
    write_reg(REG_OUT_LOW, 32'h80000000);
    write_reg(REG_OUT_HIGH, 32'h7fffffff);
    send_item(KIND_STEP, 32'h80000000);
    send_item(KIND_STEP, 32'h7fffffff);
    send_item(KIND_CLEAR, 32'h0000_0000);
    send_item(KIND_STEP, 32'h0000_0002);
    wait_idle();

    random_config(1'b1);
    while (sent < TOTAL_ITEMS) begin
      quiet = ($urandom_range(0, 5) == 0);
      phase_len = $urandom_range(20, 200);
      if (phase_len > TOTAL_ITEMS - sent) phase_len = TOTAL_ITEMS - sent;
      repeat (phase_len) begin
        if ($urandom_range(0, 24) == 0) send_item(KIND_CLEAR, $urandom());
        else send_item(KIND_STEP, rand_error());
      end
      wait_idle();
      random_config(1'b0);
    end

    quiet = 1'b0;
    wait_idle();
    if (sb.pending() != 0) sb.report("leftover drive values", sb.pending(), 32'd0);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
